/* rtl/core/mts_pkg.sv */
// shared types and constants of the multi-timer scheduler
package mts_pkg;

   localparam int MaxTimersDefault = 16;
   localparam int FireCap = 16;

   localparam logic [2:0] FUNC_TICK     = 3'd0;
   localparam logic [2:0] FUNC_ONESHOT  = 3'd1;
   localparam logic [2:0] FUNC_PERIODIC = 3'd2;
   localparam logic [2:0] FUNC_CANCEL   = 3'd3;
   localparam logic [2:0] FUNC_COMPLETE = 3'd4;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_INVALID     = 3'd1;
   localparam logic [2:0] ST_NOT_RUNNING = 3'd2;
   localparam logic [2:0] ST_LIMIT       = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND   = 3'd4;

   localparam logic [1:0] PH_PENDING   = 2'd0;
   localparam logic [1:0] PH_RUNNING   = 2'd1;
   localparam logic [1:0] PH_CANCELLED = 2'd2;

   localparam logic [0:0] REG_ENABLE = 1'b0;

   // classified command from the front to the back
   typedef enum logic [2:0] {
      OP_TICK,
      OP_SCHEDULE,
      OP_CANCEL,
      OP_COMPLETE,
      OP_REPLY
   } op_type;

   typedef struct packed {
      op_type      op;
      logic        periodic;
      logic        rate;
      logic        failed;
      logic [31:0] value;
      logic [2:0]  status;
   } cmd_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_EXEC,
      S_REPLY,
      S_FIRE
   } state_type;

endpackage

/* rtl/core/mts_front.sv */
// input side: classifies items, rejects bad ones, feeds a two-entry queue
module mts_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [2:0]          func,
   input  logic [31:0]         delay_ms,
   input  logic                rate_mode,
   input  logic [31:0]         timer_id,
   input  logic                callback_failed,
   input  logic                enable,
   output logic                q_valid,
   input  logic                q_pop,
   output mts_pkg::cmd_type    q_cmd
);

   mts_pkg::cmd_type q_ff [2];
   mts_pkg::cmd_type q_in;
   logic rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push;

   assign req_tready = (cnt_ff != 2'd2);
   assign push = req_tvalid && req_tready;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_cmd = q_ff[rd_ff];

   // classification
   always_comb begin
      q_in = '0;
      q_in.periodic = (func == mts_pkg::FUNC_PERIODIC);
      q_in.rate = rate_mode && (func == mts_pkg::FUNC_PERIODIC);
      q_in.failed = callback_failed;
      q_in.status = mts_pkg::ST_OK;
      q_in.op = mts_pkg::OP_REPLY;
      unique case (func)
         mts_pkg::FUNC_TICK: begin
            q_in.op = mts_pkg::OP_TICK;
         end
         mts_pkg::FUNC_ONESHOT, mts_pkg::FUNC_PERIODIC: begin
            q_in.value = delay_ms;
            if (delay_ms == 32'd0) q_in.status = mts_pkg::ST_INVALID;
            else if (!enable) q_in.status = mts_pkg::ST_NOT_RUNNING;
            else q_in.op = mts_pkg::OP_SCHEDULE;
         end
         mts_pkg::FUNC_CANCEL, mts_pkg::FUNC_COMPLETE: begin
            q_in.value = timer_id;
            if (timer_id == 32'd0) q_in.status = mts_pkg::ST_INVALID;
            else q_in.op = (func == mts_pkg::FUNC_CANCEL) ? mts_pkg::OP_CANCEL
                                                          : mts_pkg::OP_COMPLETE;
         end
         default: begin
            q_in.status = mts_pkg::ST_INVALID;
         end
      endcase
   end

   // queue pointers
   always_comb begin
      wr_in = push ? ~wr_ff : wr_ff;
      rd_in = q_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ff <= rd_in;
         wr_ff <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= q_in;
   end

endmodule

/* rtl/core/mts_back.sv */
// execution side: slot table, time counter, slot scan and result register
module mts_back #(
   parameter int MAX_TIMERS = mts_pkg::MaxTimersDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                q_valid,
   output logic                q_pop,
   input  mts_pkg::cmd_type    q_cmd,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [2:0]          status,
   output logic [31:0]         new_id,
   output logic                fire_valid,
   output logic [31:0]         fired_id,
   output logic                last
);

   localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
   localparam int CW = $clog2(MAX_TIMERS + 1);
   localparam int FW = $clog2(mts_pkg::FireCap + 1);

   // slot table
   logic [MAX_TIMERS-1:0] used_ff, used_in;
   logic [31:0] id_ff [MAX_TIMERS];
   logic [47:0] dl_ff [MAX_TIMERS];
   logic [31:0] per_ff [MAX_TIMERS];
   logic [MAX_TIMERS-1:0] pdc_ff;
   logic [MAX_TIMERS-1:0] rm_ff;
   logic [1:0] ph_ff [MAX_TIMERS];

   logic [47:0] now_ff, now_in;
   logic [31:0] idc_ff, idc_in;
   mts_pkg::state_type st_ff, st_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [FW-1:0] nfire_ff, nfire_in;
   logic [IW-1:0] hit_ff, hit_in;
   logic found_ff, found_in;
   logic [47:0] cand_ff, cand_in;
   logic rearm_ff;

   // status of an executed command, waiting for the result register
   logic [2:0]  xst_ff, xst_in;
   logic [31:0] xnid_ff, xnid_in;

   // result register
   logic        rv_ff, rv_in;
   logic        rhold_ff, rhold_in;
   logic [2:0]  rst_ff, rst_in;
   logic [31:0] rnid_ff, rnid_in;
   logic        rfv_ff, rfv_in;
   logic [31:0] rfid_ff, rfid_in;
   logic        rlast_ff, rlast_in;

   logic [IW-1:0] idx;
   logic at_end;
   logic cur_due, cur_match;
   logic slot_wr;
   logic [IW-1:0] wr_idx;
   logic [31:0] wr_id, wr_per;
   logic [47:0] wr_dl;
   logic wr_pdc, wr_rm;
   logic ph_wr;
   logic [1:0] ph_val;
   logic [IW-1:0] ph_idx;
   logic out_take;
   logic out_free;

   // schedule looks for the first free slot, the rest for the first id match
   function automatic logic found_in_sel(mts_pkg::op_type op, logic match, logic used);
      found_in_sel = (op == mts_pkg::OP_SCHEDULE) ? !used : match;
   endfunction

   assign idx = idx_ff[IW-1:0];
   assign at_end = (idx_ff == CW'(MAX_TIMERS));
   // a fired result is held back until it is known whether it is the last
   assign out_take = rv_ff && !rhold_ff && rsp_tready;
   assign out_free = !rv_ff || out_take;

   assign rsp_tvalid = rv_ff && !rhold_ff;
   assign status = rst_ff;
   assign new_id = rnid_ff;
   assign fire_valid = rfv_ff;
   assign fired_id = rfid_ff;
   assign last = rlast_ff;

   // per-slot tests at the scan pointer
   always_comb begin
      cur_due = 1'b0;
      cur_match = 1'b0;
      if (!at_end) begin
         cur_due = used_ff[idx] && (ph_ff[idx] == mts_pkg::PH_PENDING)
                   && (dl_ff[idx] <= now_ff);
         cur_match = used_ff[idx] && (id_ff[idx] == q_cmd.value);
      end
   end

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         mts_pkg::S_IDLE: begin
            if (q_valid) begin
               if (q_cmd.op == mts_pkg::OP_REPLY) st_in = mts_pkg::S_REPLY;
               else if (q_cmd.op == mts_pkg::OP_TICK && !enable) st_in = mts_pkg::S_IDLE;
               else st_in = mts_pkg::S_SCAN;
            end
         end
         mts_pkg::S_SCAN: begin
            if (q_cmd.op == mts_pkg::OP_TICK) begin
               if (at_end || nfire_ff == FW'(mts_pkg::FireCap))
                  st_in = mts_pkg::S_IDLE;
               else if (cur_due) st_in = mts_pkg::S_FIRE;
            end else if (at_end) begin
               st_in = mts_pkg::S_EXEC;
            end
         end
         mts_pkg::S_FIRE: begin
            if (!rhold_ff && out_free) st_in = mts_pkg::S_SCAN;
         end
         mts_pkg::S_EXEC: begin
            st_in = mts_pkg::S_REPLY;
         end
         mts_pkg::S_REPLY: begin
            if (out_free) st_in = mts_pkg::S_IDLE;
         end
         default: st_in = mts_pkg::S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      used_in = used_ff;
      now_in = now_ff;
      idc_in = idc_ff;
      idx_in = idx_ff;
      nfire_in = nfire_ff;
      hit_in = hit_ff;
      found_in = found_ff;
      cand_in = cand_ff;
      xst_in = xst_ff;
      xnid_in = xnid_ff;
      rv_in = rv_ff && !out_take;
      rhold_in = rhold_ff;
      rst_in = rst_ff;
      rnid_in = rnid_ff;
      rfv_in = rfv_ff;
      rfid_in = rfid_ff;
      rlast_in = rlast_ff;
      q_pop = 1'b0;
      slot_wr = 1'b0;
      wr_idx = hit_ff;
      wr_id = idc_ff;
      wr_per = q_cmd.periodic ? q_cmd.value : 32'd0;
      wr_dl = now_ff + 48'(q_cmd.value);
      wr_pdc = q_cmd.periodic;
      wr_rm = q_cmd.rate;
      ph_wr = 1'b0;
      ph_val = mts_pkg::PH_PENDING;
      ph_idx = hit_ff;
      unique case (st_ff)
         mts_pkg::S_IDLE: begin
            idx_in = '0;
            nfire_in = '0;
            found_in = 1'b0;
            if (q_valid && q_cmd.op == mts_pkg::OP_TICK) begin
               now_in = now_ff + 48'd1;
               if (!enable) q_pop = 1'b1;
            end
         end
         mts_pkg::S_SCAN: begin
            if (q_cmd.op == mts_pkg::OP_TICK) begin
               if (at_end || nfire_ff == FW'(mts_pkg::FireCap)) begin
                  q_pop = 1'b1;
                  // close the run on the fired result still held
                  if (rhold_ff) begin
                     rlast_in = 1'b1;
                     rhold_in = 1'b0;
                  end
               end else if (cur_due) begin
                  hit_in = idx;
               end else begin
                  idx_in = idx_ff + CW'(1);
               end
            end else if (!at_end) begin
               idx_in = idx_ff + CW'(1);
               if (!found_in_sel(q_cmd.op, cur_match, used_ff[idx])) begin
               end else if (!found_ff) begin
                  found_in = 1'b1;
                  hit_in = idx;
               end
            end
         end
         mts_pkg::S_FIRE: begin
            if (rhold_ff) begin
               // another timer is due, so the held result is not the last
               rhold_in = 1'b0;
            end else if (out_free) begin
               rv_in = 1'b1;
               rhold_in = 1'b1;
               rst_in = mts_pkg::ST_OK;
               rnid_in = '0;
               rfv_in = 1'b1;
               rfid_in = id_ff[hit_ff];
               rlast_in = 1'b0;
               ph_wr = 1'b1;
               ph_val = mts_pkg::PH_RUNNING;
               nfire_in = nfire_ff + FW'(1);
               idx_in = idx_ff + CW'(1);
            end
         end
         mts_pkg::S_EXEC: begin
            xst_in = mts_pkg::ST_OK;
            xnid_in = '0;
            cand_in = dl_ff[hit_ff] + 48'(per_ff[hit_ff]);
            unique case (q_cmd.op)
               mts_pkg::OP_SCHEDULE: begin
                  if (!found_ff) xst_in = mts_pkg::ST_LIMIT;
                  else begin
                     slot_wr = 1'b1;
                     used_in[hit_ff] = 1'b1;
                     xnid_in = idc_ff;
                     idc_in = (idc_ff == 32'hFFFF_FFFF) ? 32'd1 : idc_ff + 32'd1;
                  end
               end
               mts_pkg::OP_CANCEL: begin
                  if (!found_ff || ph_ff[hit_ff] == mts_pkg::PH_CANCELLED)
                     xst_in = mts_pkg::ST_NOT_FOUND;
                  else if (ph_ff[hit_ff] == mts_pkg::PH_PENDING)
                     used_in[hit_ff] = 1'b0;
                  else begin
                     ph_wr = 1'b1;
                     ph_val = mts_pkg::PH_CANCELLED;
                  end
               end
               mts_pkg::OP_COMPLETE: begin
                  if (!found_ff || ph_ff[hit_ff] == mts_pkg::PH_PENDING)
                     xst_in = mts_pkg::ST_NOT_FOUND;
                  else if (ph_ff[hit_ff] == mts_pkg::PH_CANCELLED || q_cmd.failed
                           || !pdc_ff[hit_ff])
                     used_in[hit_ff] = 1'b0;
                  else begin
                     ph_wr = 1'b1;
                     ph_val = mts_pkg::PH_PENDING;
                  end
               end
               default: begin
               end
            endcase
         end
         mts_pkg::S_REPLY: begin
            if (out_free) begin
               rv_in = 1'b1;
               if (q_cmd.op == mts_pkg::OP_REPLY) begin
                  rst_in = q_cmd.status;
                  rnid_in = '0;
               end else begin
                  rst_in = xst_ff;
                  rnid_in = xnid_ff;
               end
               rfv_in = 1'b0;
               rfid_in = '0;
               rlast_in = 1'b1;
               q_pop = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= mts_pkg::S_IDLE;
         used_ff <= '0;
         now_ff <= '0;
         idc_ff <= 32'd1;
         rv_ff <= 1'b0;
         rhold_ff <= 1'b0;
         idx_ff <= '0;
         nfire_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         used_ff <= used_in;
         now_ff <= now_in;
         idc_ff <= idc_in;
         rv_ff <= rv_in;
         rhold_ff <= rhold_in;
         idx_ff <= idx_in;
         nfire_ff <= nfire_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
      cand_ff <= cand_in;
      xst_ff <= xst_in;
      xnid_ff <= xnid_in;
      rst_ff <= rst_in;
      rnid_ff <= rnid_in;
      rfv_ff <= rfv_in;
      rfid_ff <= rfid_in;
      rlast_ff <= rlast_in;
   end

   // slot table writes; a rate re-arm may take the sum registered in exec
   always_ff @(posedge clock) begin
      if (slot_wr) begin
         id_ff[wr_idx] <= wr_id;
         dl_ff[wr_idx] <= wr_dl;
         per_ff[wr_idx] <= wr_per;
         pdc_ff[wr_idx] <= wr_pdc;
         rm_ff[wr_idx] <= wr_rm;
         ph_ff[wr_idx] <= mts_pkg::PH_PENDING;
      end else if (ph_wr) begin
         ph_ff[ph_idx] <= ph_val;
      end
      if (st_ff == mts_pkg::S_REPLY && out_free && q_cmd.op == mts_pkg::OP_COMPLETE
          && rearm_ff) begin
         if (!rm_ff[hit_ff] || cand_ff <= now_ff)
            dl_ff[hit_ff] <= now_ff + 48'(per_ff[hit_ff]);
         else
            dl_ff[hit_ff] <= cand_ff;
      end
   end

   // remembers that exec re-armed a periodic timer
   always_ff @(posedge clock) begin
      if (st_ff == mts_pkg::S_EXEC)
         rearm_ff <= ph_wr && q_cmd.op == mts_pkg::OP_COMPLETE;
   end

endmodule

/* rtl/core/multi_timer_scheduler.sv */
// top level: configuration register, front classifier and back executor
// Takes items through a two-entry queue and works on one at a time. A schedule,
// cancel or completion walks the slot table one slot per cycle, then answers.
// A tick, when enabled, walks the table the same way, pausing to fire each due
// timer, longer while the result register is busy, and stops at the end or after
// FireCap fires; each fired result is held back until the next due timer or
// the end of the walk shows whether it is the last. Rejected items answer
// without a walk. The enable register sits at csr addresses 0 to 3 (paddr[2] = 0).
module multi_timer_scheduler #(
   parameter int MAX_TIMERS = mts_pkg::MaxTimersDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // func[2:0], delay_ms[34:3], rate_mode[35], timer_id[67:36], failed[68]
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[2:0], new_id[34:3], fired_id[66:35]
   output logic [71:0] rsp_tdata,
   // fire_valid
   output logic        rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic enable_ff, enable_in;
   logic q_valid, q_pop;
   mts_pkg::cmd_type q_cmd;
   logic [2:0] status;
   logic [31:0] new_id, fired_id;

   assign csr_pready = 1'b1;

   // enable register
   always_comb begin
      enable_in = enable_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == mts_pkg::REG_ENABLE)
         enable_in = csr_pwdata[0];
      csr_prdata = (csr_paddr[2] == mts_pkg::REG_ENABLE) ? {31'd0, enable_ff} : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) enable_ff <= 1'b0;
      else enable_ff <= enable_in;
   end

   mts_front u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .func(req_tdata[2:0]), .delay_ms(req_tdata[34:3]),
      .rate_mode(req_tdata[35]), .timer_id(req_tdata[67:36]),
      .callback_failed(req_tdata[68]),
      .enable(enable_ff),
      .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd)
   );

   mts_back #(.MAX_TIMERS(MAX_TIMERS)) u_back (
      .clock(clock), .reset(reset), .enable(enable_ff),
      .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .status(status), .new_id(new_id), .fire_valid(rsp_tuser),
      .fired_id(fired_id), .last(rsp_tlast)
   );

   assign rsp_tdata = {5'd0, fired_id, new_id, status};

endmodule
